FILE: rtl/smseq_pkg.sv
package smseq_pkg;

  // Field and register widths
  localparam int TickW  = 32;
  localparam int RemW   = 31;
  localparam int PosW   = 16;
  localparam int ReqW   = 32;
  localparam int CfgIdW = 2;
  localparam int CfgDW  = 32;

  // Item kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdW-1:0] CFG_STEPS_PER_TURN = 2'd0;
  localparam logic [CfgIdW-1:0] CFG_STEP_INTERVAL  = 2'd1;

  // Reset values of the configuration registers
  localparam logic [PosW-1:0]  SPT_RESET      = 16'd200;
  localparam logic [TickW-1:0] INTERVAL_RESET = '0;

  // Motion state
  typedef struct packed {
    logic [TickW-1:0] ticks;
    logic [RemW-1:0]  remaining;
    logic             forward;
    logic [PosW-1:0]  position;
    logic [1:0]       coil;
  } smseq_state_t;

  // One result word
  typedef struct packed {
    logic            coil_one;
    logic            coil_two;
    logic            step_taken;
    logic            busy_res;
    logic            move_done;
    logic            rejected;
    logic [PosW-1:0] turn_position;
  } smseq_result_t;

  // Coil code 00,01,11,10 indexed by position mod 4
  function automatic logic [1:0] coil_code(input logic [1:0] phase);
    coil_code = {phase[1], phase[1] ^ phase[0]};
  endfunction

endpackage

FILE: rtl/stepper_move_sequencer_core.sv
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_valid / in_stall    | func, move_steps
// out_    | output    | out_valid / out_stall  | coil_one, coil_two, step_taken,
//         |           |                        | busy_res, move_done, rejected,
//         |           |                        | turn_position
// cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle while in_stall is low; each result word is registered.
// The state update and result logic sit between the state registers and a
// two-entry output buffer (result register plus skid register).
// in_stall rises only when both output entries are full; it is registered.
// Synchronous active-low reset clears motion state and loads register defaults.
module stepper_move_sequencer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [smseq_pkg::ReqW-1:0]    in_move_steps,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_coil_one,
  output logic                          out_coil_two,
  output logic                          out_step_taken,
  output logic                          out_busy_res,
  output logic                          out_move_done,
  output logic                          out_rejected,
  output logic [smseq_pkg::PosW-1:0]    out_turn_position,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smseq_pkg::CfgIdW-1:0]  cfg_index,
  input  logic [smseq_pkg::CfgDW-1:0]   cfg_data
);
  import smseq_pkg::*;

  logic [PosW-1:0]  steps_per_turn_r;
  logic [TickW-1:0] step_interval_r;
  smseq_state_t     state_r;
  smseq_state_t     state_nxt;
  smseq_result_t    res_nxt;
  smseq_result_t    out_res_r;
  smseq_result_t    skid_res_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             in_take;
  logic             out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_per_turn_r <= SPT_RESET;
      step_interval_r  <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEPS_PER_TURN: steps_per_turn_r <= cfg_data[PosW-1:0];
        CFG_STEP_INTERVAL:  step_interval_r  <= cfg_data[TickW-1:0];
        default: ;
      endcase
    end
  end

  smseq_step_unit u_step (
    .cur            (state_r),
    .func           (in_func),
    .move_steps     (in_move_steps),
    .steps_per_turn (steps_per_turn_r),
    .step_interval  (step_interval_r),
    .nxt            (state_nxt),
    .res            (res_nxt)
  );

  // Motion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Output buffer: result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_res_r    <= skid_res_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_res_r   <= res_nxt;
        out_valid_r <= 1'b1;
      end else begin
        skid_res_r   <= res_nxt;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coil_one      = out_res_r.coil_one;
  assign out_coil_two      = out_res_r.coil_two;
  assign out_step_taken    = out_res_r.step_taken;
  assign out_busy_res      = out_res_r.busy_res;
  assign out_move_done     = out_res_r.move_done;
  assign out_rejected      = out_res_r.rejected;
  assign out_turn_position = out_res_r.turn_position;

`ifndef SYNTH
  // Skid entry is only used behind a full result register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty result register");

  // A result word never reports both a step and a rejected command
  a_step_or_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.step_taken && out_res_r.rejected))
    else $error("step and reject in one word");

  // Final step of a move leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.move_done) |-> (out_res_r.step_taken && !out_res_r.busy_res))
    else $error("move done flagged without final step");

  // A command taken while busy leaves the step count alone
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_func == FUNC_MOVE) && (state_r.remaining != '0))
      |=> $stable(state_r.remaining))
    else $error("rejected command changed step count");
`endif

endmodule

FILE: rtl/smseq_step_unit.sv
module smseq_step_unit (
  input  smseq_pkg::smseq_state_t          cur,
  input  logic                             func,
  input  logic [smseq_pkg::ReqW-1:0]       move_steps,
  input  logic [smseq_pkg::PosW-1:0]       steps_per_turn,
  input  logic [smseq_pkg::TickW-1:0]      step_interval,
  output smseq_pkg::smseq_state_t          nxt,
  output smseq_pkg::smseq_result_t         res
);
  import smseq_pkg::*;

  logic [TickW-1:0] ticks_inc;
  logic             step_now;
  logic [PosW-1:0]  pos_fwd;
  logic [PosW-1:0]  pos_rev_base;
  logic [PosW-1:0]  pos_step;
  logic [ReqW-1:0]  req_neg;
  logic [RemW-1:0]  req_mag;
  logic             busy;

  // Per-tick arithmetic
  always_comb begin
    ticks_inc    = (cur.ticks == '1) ? cur.ticks : cur.ticks + 1'b1;
    busy         = (cur.remaining != '0);
    step_now     = busy && (ticks_inc >= step_interval);
    pos_fwd      = cur.position + 1'b1;
    if (pos_fwd == steps_per_turn) begin
      pos_fwd = '0;
    end
    pos_rev_base = (cur.position == '0) ? steps_per_turn : cur.position;
    pos_step     = cur.forward ? pos_fwd : pos_rev_base - 1'b1;
  end

  // Magnitude of a move request, most negative value saturates
  always_comb begin
    req_neg = (~move_steps) + 1'b1;
    if (move_steps[ReqW-1]) begin
      req_mag = req_neg[ReqW-1] ? '1 : req_neg[RemW-1:0];
    end else begin
      req_mag = move_steps[RemW-1:0];
    end
  end

  // Next state and result word
  always_comb begin
    nxt = cur;
    res = '0;
    if (func == FUNC_MOVE) begin
      if (busy) begin
        res.rejected = 1'b1;
      end else begin
        nxt.remaining = req_mag;
        nxt.forward   = !move_steps[ReqW-1] && (move_steps != '0);
        nxt.position  = '0;
      end
    end else begin
      nxt.ticks = ticks_inc;
      if (step_now) begin
        nxt.ticks      = '0;
        nxt.position   = pos_step;
        nxt.remaining  = cur.remaining - 1'b1;
        nxt.coil       = coil_code(pos_step[1:0]);
        res.step_taken = 1'b1;
        res.move_done  = (cur.remaining == RemW'(1));
      end
    end
    res.coil_one      = nxt.coil[1];
    res.coil_two      = nxt.coil[0];
    res.busy_res      = (nxt.remaining != '0);
    res.turn_position = nxt.position;
  end

endmodule

FILE: tb/tb_stepper_move_sequencer_core.sv
`timescale 1ns / 100ps

module tb_stepper_move_sequencer_core;
  import smseq_pkg::*;

  // One input word as queued for the driver
  typedef struct packed {
    logic            func;
    logic [ReqW-1:0] steps;
  } move_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_func = FUNC_TICK;
  logic [ReqW-1:0]     in_move_steps = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_coil_one;
  logic                out_coil_two;
  logic                out_step_taken;
  logic                out_busy_res;
  logic                out_move_done;
  logic                out_rejected;
  logic [PosW-1:0]     out_turn_position;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdW-1:0]   cfg_index = CFG_STEPS_PER_TURN;
  logic [CfgDW-1:0]    cfg_data = '0;

  stepper_move_sequencer_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_move_steps     (in_move_steps),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_coil_one      (out_coil_one),
    .out_coil_two      (out_coil_two),
    .out_step_taken    (out_step_taken),
    .out_busy_res      (out_busy_res),
    .out_move_done     (out_move_done),
    .out_rejected      (out_rejected),
    .out_turn_position (out_turn_position),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Motor state as the testbench tracks it
  logic [PosW-1:0]  spt_m   = SPT_RESET;
  logic [TickW-1:0] intv_m  = INTERVAL_RESET;
  logic [TickW-1:0] ticks_m = '0;
  logic [RemW-1:0]  rem_m   = '0;
  logic             fwd_m   = 1'b0;
  logic [PosW-1:0]  pos_m   = '0;
  logic [1:0]       coil_m  = 2'b00;

  move_word_t    move_words[$];
  smseq_result_t motor_results[$];
  int            words_queued = 0;
  int            words_taken  = 0;
  int            fail_count   = 0;
  logic          no_idle      = 1'b0;
  int            hold_reqs    = 0;
  int            holds_served = 0;
  int            hold_left    = 0;

  // Coil code 00,01,11,10 by position mod 4
  function automatic logic [1:0] phase_to_coils(input logic [1:0] phase);
    case (phase)
      2'd0: phase_to_coils = 2'b00;
      2'd1: phase_to_coils = 2'b01;
      2'd2: phase_to_coils = 2'b11;
      default: phase_to_coils = 2'b10;
    endcase
  endfunction

  // Apply one accepted word to the tracked state, queue the expected result
  task automatic advance_motor(input logic func, input logic [ReqW-1:0] req);
    logic [ReqW-1:0] mag;
    logic            taken;
    logic            done;
    logic            rej;
    taken = 1'b0;
    done  = 1'b0;
    rej   = 1'b0;
    if (func == FUNC_MOVE) begin
      if (rem_m != '0) begin
        rej = 1'b1;
      end else begin
        if (req[ReqW-1]) begin
          mag = ~req + 32'd1;
          // most negative request saturates
          if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
          fwd_m = 1'b0;
        end else begin
          mag   = req;
          fwd_m = (req != '0);
        end
        rem_m = mag[RemW-1:0];
        pos_m = '0;
      end
    end else begin
      if (ticks_m != '1) ticks_m = ticks_m + 32'd1;
      if (rem_m != '0 && ticks_m >= intv_m) begin
        ticks_m = '0;
        if (fwd_m) begin
          pos_m = pos_m + 16'd1;
          if (pos_m == spt_m) pos_m = '0;
        end else begin
          if (pos_m == '0) pos_m = spt_m;
          pos_m = pos_m - 16'd1;
        end
        rem_m  = rem_m - 31'd1;
        coil_m = phase_to_coils(pos_m[1:0]);
        taken  = 1'b1;
        done   = (rem_m == '0);
      end
    end
    motor_results.push_back({coil_m[1], coil_m[0], taken, rem_m != '0, done, rej, pos_m});
  endtask

  function automatic string show_result(input smseq_result_t r);
    show_result = $sformatf("coils=%b%b step=%b busy=%b done=%b rej=%b pos=%0d",
                            r.coil_one, r.coil_two, r.step_taken, r.busy_res,
                            r.move_done, r.rejected, r.turn_position);
  endfunction

  // Driver: predicts on each accepted word, then offers the next one
  always @(posedge clk) begin : drive_words
    move_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_motor(in_func, in_move_steps);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (move_words.size() > 0 && (no_idle || $urandom_range(0, 99) >= 14)) begin
          w = move_words.pop_front();
          in_valid      <= 1'b1;
          in_func       <= w.func;
          in_move_steps <= w.steps;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: random stalls plus requested long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_served) begin
      out_stall    <= 1'b1;
      hold_left    <= 150;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 14);
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    smseq_result_t got;
    smseq_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_coil_one, out_coil_two, out_step_taken, out_busy_res,
             out_move_done, out_rejected, out_turn_position};
      if (motor_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word: %s", show_result(got));
      end else begin
        want = motor_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(got));
          end
        end
      end
    end
  end

  task automatic push_word(input logic func, input logic [ReqW-1:0] steps);
    move_words.push_back('{func: func, steps: steps});
    words_queued++;
  endtask

  // Ticks carry random payload, which the block ignores
  task automatic push_ticks(input int n);
    repeat (n) push_word(FUNC_TICK, $urandom());
  endtask

  function automatic logic [ReqW-1:0] random_sign(input int mag);
    random_sign = $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Register write; block is quiet on the data path when called
  task automatic write_reg(input logic [CfgIdW-1:0] idx, input logic [CfgDW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_STEPS_PER_TURN) spt_m = val[PosW-1:0];
    else if (idx == CFG_STEP_INTERVAL) intv_m = val;
    @(posedge clk);
  endtask

  // Hold the sender until every queued word has its result back
  task automatic wait_drained();
    @(negedge clk);
    while (words_taken != words_queued || motor_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly complete moves with enough ticks to finish them; some broken
  // moves, stray commands and tick bursts. A wide command right after a
  // nonzero move always lands while busy, so it is rejected.
  task automatic queue_runs(input int n_items, input int max_mag);
    int start;
    int per;
    int roll;
    int mag;
    int n;
    start = words_queued;
    per   = (intv_m == 0) ? 1 : int'(intv_m);
    while (words_queued - start < n_items) begin
      roll = $urandom_range(0, 99);
      mag  = $urandom_range(0, max_mag);
      if (roll < 80) begin
        push_word(FUNC_MOVE, random_sign(mag));
        if (mag > 0 && $urandom_range(0, 3) == 0) push_word(FUNC_MOVE, $urandom());
        n = mag * per + $urandom_range(0, 3);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0)
            push_word(FUNC_MOVE, random_sign($urandom_range(0, max_mag)));
          push_word(FUNC_TICK, $urandom());
        end
      end else if (roll < 92) begin
        push_word(FUNC_MOVE, random_sign(mag));
        push_ticks($urandom_range(0, mag * per));
      end else begin
        push_ticks($urandom_range(1, 8));
      end
    end
    // let any leftover move run out
    push_ticks(max_mag * per + 2);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle ticks, zero request, rejects, wrap both ways
    write_reg(CFG_STEPS_PER_TURN, 32'd8);
    write_reg(CFG_STEP_INTERVAL, 32'd0);
    @(negedge clk);
    push_ticks(2);
    push_word(FUNC_MOVE, 32'd0);
    push_ticks(1);
    push_word(FUNC_MOVE, 32'd4);
    push_word(FUNC_MOVE, 32'd3);
    push_word(FUNC_MOVE, 32'h7FFF_FFFF);
    push_word(FUNC_MOVE, 32'h8000_0001);
    push_ticks(4);
    push_word(FUNC_MOVE, -32'sd3);
    push_ticks(3);
    push_word(FUNC_MOVE, 32'd9);
    push_ticks(9);
    wait_drained();

    // Largest interval stalls the move; largest turn size on a reverse move
    write_reg(CFG_STEPS_PER_TURN, 32'h0000_FFFF);
    write_reg(CFG_STEP_INTERVAL, 32'hFFFF_FFFF);
    @(negedge clk);
    push_word(FUNC_MOVE, -32'sd2);
    push_ticks(6);
    push_word(FUNC_MOVE, 32'd1);
    wait_drained();
    write_reg(CFG_STEP_INTERVAL, 32'd1);
    @(negedge clk);
    push_ticks(4);
    wait_drained();

    // Turn size shrunk below the position mid-move, forward then reverse
    write_reg(CFG_STEPS_PER_TURN, 32'd300);
    write_reg(CFG_STEP_INTERVAL, 32'd0);
    @(negedge clk);
    push_word(FUNC_MOVE, 32'd40);
    push_ticks(25);
    wait_drained();
    write_reg(CFG_STEPS_PER_TURN, 32'd6);
    @(negedge clk);
    push_ticks(20);
    wait_drained();
    write_reg(CFG_STEPS_PER_TURN, 32'd300);
    @(negedge clk);
    push_word(FUNC_MOVE, -32'sd10);
    push_ticks(3);
    wait_drained();
    write_reg(CFG_STEPS_PER_TURN, 32'd50);
    @(negedge clk);
    push_ticks(10);
    wait_drained();

    // Random runs, first with no idling on either side
    write_reg(CFG_STEPS_PER_TURN, 32'd200);
    @(negedge clk);
    no_idle = 1'b1;
    queue_runs(400, 12);
    wait_drained();
    @(negedge clk);
    no_idle = 1'b0;

    // Long receiver hold-off while words keep coming
    write_reg(CFG_STEPS_PER_TURN, 32'd5);
    write_reg(CFG_STEP_INTERVAL, 32'd2);
    @(negedge clk);
    queue_runs(400, 15);
    hold_reqs++;
    wait_drained();

    // One-step turn
    write_reg(CFG_STEPS_PER_TURN, 32'd1);
    write_reg(CFG_STEP_INTERVAL, 32'd1);
    @(negedge clk);
    queue_runs(300, 10);
    wait_drained();

    write_reg(CFG_STEPS_PER_TURN, $urandom_range(2, 40));
    write_reg(CFG_STEP_INTERVAL, $urandom_range(0, 3));
    @(negedge clk);
    queue_runs(350, 20);
    wait_drained();

    // Most negative request saturates; block then stays busy, all commands rejected
    write_reg(CFG_STEPS_PER_TURN, 32'd13);
    write_reg(CFG_STEP_INTERVAL, 32'd0);
    @(negedge clk);
    push_word(FUNC_MOVE, 32'h8000_0000);
    push_word(FUNC_MOVE, 32'h7FFF_FFFF);
    repeat (20) begin
      push_word(FUNC_TICK, $urandom());
      push_word(FUNC_MOVE, $urandom());
    end
    wait_drained();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && motor_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
